// ===== rtl/cmap_pkg.sv =====
// ----------------------------------------------------------------------------
// cmap_pkg
// shared widths, codes and types of the scalar to rgb colormap pipeline
// ----------------------------------------------------------------------------
package cmap_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = FRAC_W + 1;
	localparam int REM_W    = SAMPLE_W + 1;
	localparam int CHAN_W   = 8;
	localparam int SEL_W    = 3;
	localparam int ADDR_W   = 2;
	localparam int LATENCY  = QUO_W + 3;

	typedef enum logic [SEL_W-1:0] {
		MAP_GRAY   = 3'd0,
		MAP_RG     = 3'd1,
		MAP_AUTUMN = 3'd2,
		MAP_HOT    = 3'd3,
		MAP_JET    = 3'd4
	} map_t;

	typedef enum logic [ADDR_W-1:0] {
		CFG_MIN = 2'd0,
		CFG_MAX = 2'd1,
		CFG_SEL = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             err;
		logic             empty;
		logic [SEL_W-1:0] sel;
	} side_t;

	typedef struct packed {
		logic [QUO_W-1:0] r;
		logic [QUO_W-1:0] g;
		logic [QUO_W-1:0] b;
	} chan_n_t;

endpackage

// ===== rtl/cmap_norm.sv =====
// ----------------------------------------------------------------------------
// cmap_norm
// clamps the sample into the configured range and forms numerator and span
// ----------------------------------------------------------------------------
module cmap_norm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [cmap_pkg::SAMPLE_W-1:0] sample,
	input  logic [cmap_pkg::SAMPLE_W-1:0] min_value,
	input  logic [cmap_pkg::SAMPLE_W-1:0] max_value,
	input  logic [cmap_pkg::SEL_W-1:0]    map_select,
	output logic                          vld_s1,
	output logic [cmap_pkg::SAMPLE_W-1:0] num_s1,
	output logic [cmap_pkg::SAMPLE_W-1:0] den_s1,
	output cmap_pkg::side_t               side_s1
);

	logic                          below;
	logic                          above;
	logic                          empty;
	logic [cmap_pkg::SAMPLE_W-1:0] clamped;

	always_comb begin
		empty   = (max_value <= min_value);
		below   = (sample < min_value);
		above   = (sample > max_value);
		clamped = sample;
		if (below) begin
			clamped = min_value;
		end else if (above) begin
			clamped = max_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		num_s1        <= clamped - min_value;
		den_s1        <= max_value - min_value;
		side_s1.empty <= empty;
		side_s1.err   <= empty | below | above;
		side_s1.sel   <= map_select;
	end

endmodule

// ===== rtl/cmap_div.sv =====
// ----------------------------------------------------------------------------
// cmap_div
// restoring divider, one quotient bit per stage, gives floor(num*2^16/den)
// ----------------------------------------------------------------------------
module cmap_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [cmap_pkg::SAMPLE_W-1:0] num,
	input  logic [cmap_pkg::SAMPLE_W-1:0] den,
	input  cmap_pkg::side_t               in_side,
	output logic                          out_vld,
	output logic [cmap_pkg::QUO_W-1:0]    quo,
	output cmap_pkg::side_t               out_side
);

	localparam int N = cmap_pkg::QUO_W;
	localparam int SW = cmap_pkg::SAMPLE_W;

	logic [N-1:0]                     vld_sn;
	logic [SW-1:0]                    rem_sn  [N];
	logic [N-1:0]                     quo_sn  [N];
	logic [SW-1:0]                    den_sn  [N];
	cmap_pkg::side_t                  side_sn [N];

	logic                             src_vld  [N];
	logic [cmap_pkg::REM_W-1:0]       trial    [N];
	logic [N-1:0]                     src_quo  [N];
	logic [SW-1:0]                    src_den  [N];
	cmap_pkg::side_t                  src_side [N];
	logic [cmap_pkg::REM_W-1:0]       diff     [N];
	logic                             qbit     [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign src_vld[i]  = in_vld;
			assign trial[i]    = {1'b0, num};
			assign src_quo[i]  = '0;
			assign src_den[i]  = den;
			assign src_side[i] = in_side;
		end else begin : g_next
			assign src_vld[i]  = vld_sn[i-1];
			assign trial[i]    = {rem_sn[i-1], 1'b0};
			assign src_quo[i]  = quo_sn[i-1];
			assign src_den[i]  = den_sn[i-1];
			assign src_side[i] = side_sn[i-1];
		end

		assign diff[i] = trial[i] - {1'b0, src_den[i]};
		assign qbit[i] = (trial[i] >= {1'b0, src_den[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[i] <= 1'b0;
			end else begin
				vld_sn[i] <= src_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[i]  <= qbit[i] ? diff[i][SW-1:0] : trial[i][SW-1:0];
			quo_sn[i]  <= {src_quo[i][N-2:0], qbit[i]};
			den_sn[i]  <= src_den[i];
			side_sn[i] <= src_side[i];
		end
	end

	assign out_vld  = vld_sn[N-1];
	assign quo      = quo_sn[N-1];
	assign out_side = side_sn[N-1];

endmodule

// ===== rtl/cmap_color.sv =====
// ----------------------------------------------------------------------------
// cmap_color
// picks the colormap segment per channel, then scales each channel to 8 bits
// ----------------------------------------------------------------------------
module cmap_color (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [cmap_pkg::QUO_W-1:0]  v,
	input  cmap_pkg::side_t             in_side,
	output logic                        done,
	output logic [cmap_pkg::CHAN_W-1:0] red,
	output logic [cmap_pkg::CHAN_W-1:0] green,
	output logic [cmap_pkg::CHAN_W-1:0] blue,
	output logic                        range_error
);

	localparam int QW = cmap_pkg::QUO_W;
	localparam int TW = QW + 3;
	localparam int PW = QW + cmap_pkg::CHAN_W;
	localparam logic [TW-1:0] ONE_T   = TW'(1) << cmap_pkg::FRAC_W;
	localparam logic [TW-1:0] TWO_T   = ONE_T + ONE_T;
	localparam logic [TW-1:0] THREE_T = TWO_T + ONE_T;
	localparam logic [TW-1:0] FOUR_T  = THREE_T + ONE_T;
	localparam logic [TW-1:0] FIVE_T  = FOUR_T + ONE_T;
	localparam logic [QW-1:0] ONE_N   = QW'(1) << cmap_pkg::FRAC_W;

	logic [TW-1:0]    t3;
	logic [TW-1:0]    t5;
	logic [TW-1:0]    vt;
	cmap_pkg::chan_n_t n_c;

	logic              vld_s1;
	logic              err_s1;
	cmap_pkg::chan_n_t n_s1;

	logic [PW-1:0] pr;
	logic [PW-1:0] pg;
	logic [PW-1:0] pb;

	always_comb begin
		vt  = TW'(v);
		t3  = vt + (vt << 1);
		t5  = vt + (vt << 2);
		n_c = '0;
		case (in_side.sel)
			cmap_pkg::MAP_RG: begin
				n_c.r = ONE_N - v;
				n_c.g = v;
			end
			cmap_pkg::MAP_AUTUMN: begin
				n_c.r = ONE_N;
				n_c.g = v;
			end
			cmap_pkg::MAP_HOT: begin
				if (t3 < ONE_T) begin
					n_c.r = t3[QW-1:0];
				end else if (t3 < TWO_T) begin
					n_c.r = ONE_N;
					n_c.g = QW'(t3 - ONE_T);
				end else begin
					n_c.r = ONE_N;
					n_c.g = ONE_N;
					n_c.b = QW'(t3 - TWO_T);
				end
			end
			cmap_pkg::MAP_JET: begin
				if (t5 < ONE_T) begin
					n_c.b = t5[QW-1:0];
				end else if (t5 < TWO_T) begin
					n_c.g = QW'(t5 - ONE_T);
					n_c.b = ONE_N;
				end else if (t5 < THREE_T) begin
					n_c.g = ONE_N;
					n_c.b = QW'(THREE_T - t5);
				end else if (t5 < FOUR_T) begin
					n_c.r = QW'(t5 - THREE_T);
					n_c.g = ONE_N;
				end else begin
					n_c.r = ONE_N;
					n_c.g = QW'(FIVE_T - t5);
				end
			end
			default: begin
				n_c.r = v;
				n_c.g = v;
				n_c.b = v;
			end
		endcase
		if (in_side.empty) begin
			n_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s1   <= n_c;
		err_s1 <= in_side.err;
	end

	// times 255 as times 256 minus one
	assign pr = {n_s1.r, {cmap_pkg::CHAN_W{1'b0}}} - PW'(n_s1.r);
	assign pg = {n_s1.g, {cmap_pkg::CHAN_W{1'b0}}} - PW'(n_s1.g);
	assign pb = {n_s1.b, {cmap_pkg::CHAN_W{1'b0}}} - PW'(n_s1.b);

	always_ff @(posedge clk) begin
		red         <= pr[cmap_pkg::FRAC_W +: cmap_pkg::CHAN_W];
		green       <= pg[cmap_pkg::FRAC_W +: cmap_pkg::CHAN_W];
		blue        <= pb[cmap_pkg::FRAC_W +: cmap_pkg::CHAN_W];
		range_error <= err_s1;
	end

endmodule

// ===== rtl/scalar_to_rgb_colormap.sv =====
// an accepted sample passes the norm, divider and color registers to done
// throughput: one sample per cycle, busy is never raised
// the depth is set by the divider, one quotient bit per stage over 17 stages
// done marks each result for exactly one cycle, the receiver cannot stall
// reset clears all valid bits and loads min 0, max 65535, gray map
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap
// normalizes a sample against min and max and maps it to an rgb color
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cmap_pkg::SAMPLE_W-1:0] sample,
	output logic                          done,
	output logic [cmap_pkg::CHAN_W-1:0]   red,
	output logic [cmap_pkg::CHAN_W-1:0]   green,
	output logic [cmap_pkg::CHAN_W-1:0]   blue,
	output logic                          range_error,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cmap_pkg::ADDR_W-1:0]   cfg_addr,
	input  logic [cmap_pkg::SAMPLE_W-1:0] cfg_data
);

	logic [cmap_pkg::SAMPLE_W-1:0] min_q;
	logic [cmap_pkg::SAMPLE_W-1:0] max_q;
	logic [cmap_pkg::SEL_W-1:0]    sel_q;

	logic                          norm_vld;
	logic [cmap_pkg::SAMPLE_W-1:0] norm_num;
	logic [cmap_pkg::SAMPLE_W-1:0] norm_den;
	cmap_pkg::side_t               norm_side;

	logic                          div_vld;
	logic [cmap_pkg::QUO_W-1:0]    div_quo;
	cmap_pkg::side_t               div_side;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
			sel_q <= cmap_pkg::MAP_GRAY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				cmap_pkg::CFG_MIN: min_q <= cfg_data;
				cmap_pkg::CFG_MAX: max_q <= cfg_data;
				cmap_pkg::CFG_SEL: sel_q <= cfg_data[cmap_pkg::SEL_W-1:0];
				default: ;
			endcase
		end
	end

	cmap_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (start && !busy),
		.sample     (sample),
		.min_value  (min_q),
		.max_value  (max_q),
		.map_select (sel_q),
		.vld_s1     (norm_vld),
		.num_s1     (norm_num),
		.den_s1     (norm_den),
		.side_s1    (norm_side)
	);

	cmap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (norm_vld),
		.num      (norm_num),
		.den      (norm_den),
		.in_side  (norm_side),
		.out_vld  (div_vld),
		.quo      (div_quo),
		.out_side (div_side)
	);

	cmap_color u_color (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (div_vld),
		.v           (div_quo),
		.in_side     (div_side),
		.done        (done),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.range_error (range_error)
	);

`ifndef ASSERT_OFF
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(cmap_pkg::LATENCY) done)
		else $error("accepted beat did not come out");

	a_beat_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, cmap_pkg::LATENCY))
		else $error("result without accepted beat");

	a_empty_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && (max_q <= min_q) |->
			red == '0 && green == '0 && blue == '0 && range_error)
		else $error("empty range not black with error");

	a_autumn_red: assert property (@(posedge clk) disable iff (!arst_n)
		done && sel_q == cmap_pkg::MAP_AUTUMN && (max_q > min_q) |-> red == '1)
		else $error("autumn map red not full");
`endif

endmodule
